/* hdl/pwlm_pkg.sv */
// shared types and constants of the plus-window local maximum finder
`timescale 1ns / 1ps
`default_nettype none

package pwlm_pkg;

    // payload widths
    localparam int SAMPLE_W = 16;
    localparam int ROW_W    = 12;
    localparam int COL_W    = 10;
    localparam int FW_W     = 11;
    localparam int FH_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // reset values of the configuration registers
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd1024;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [ROW_W-1:0]    row_t;
    typedef logic [COL_W-1:0]    peak_col_t;

    // per-pixel position flags from the position tracker
    typedef struct packed {
        logic cand;       // interior pixel of the row above can be decided
        logic has_right;  // a right neighbour exists in the row above
    } pos_flags_t;

    // one reported peak
    typedef struct packed {
        row_t      row;
        peak_col_t col;
        sample_t   value;
    } peak_t;

endpackage

`default_nettype wire

/* hdl/pwlm_pixel_if.sv */
// pixel stream channel: valid/ready handshake with sample and frame flag
`timescale 1ns / 1ps
`default_nettype none

interface pwlm_pixel_if;
    logic                  valid;
    logic                  ready;
    logic [16-1:0]         pixel_value;
    logic                  frame_start;

    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

`default_nettype wire

/* hdl/pwlm_peak_if.sv */
// peak report channel: valid/ready handshake with row, column and value
`timescale 1ns / 1ps
`default_nettype none

interface pwlm_peak_if;
    logic          valid;
    logic          ready;
    logic [12-1:0] peak_row;
    logic [10-1:0] peak_col;
    logic [16-1:0] peak_value;

    modport source (output valid, output peak_row, output peak_col, output peak_value,
                    input ready);
    modport sink   (input valid, input peak_row, input peak_col, input peak_value,
                    output ready);
endinterface

`default_nettype wire

/* hdl/pwlm_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module pwlm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/pwlm_pos.sv */
// row and column tracker with frame wrap and window eligibility flags
`timescale 1ns / 1ps
`default_nettype none

module pwlm_pos #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic                         frame_start,
    input  wire logic [pwlm_pkg::FW_W-1:0]    frame_width,
    input  wire logic [pwlm_pkg::FH_W-1:0]    frame_height,
    output logic      [$clog2(MAX_WIDTH)-1:0] col,
    output logic      [$clog2(MAX_WIDTH)-1:0] col_right,
    output pwlm_pkg::row_t                    row,
    output pwlm_pkg::pos_flags_t              flags
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int XW = ((WB > pwlm_pkg::FW_W) ? WB : pwlm_pkg::FW_W) + 1;
    localparam int RW = pwlm_pkg::ROW_W;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic [XW-1:0] w_use;
    logic [RW-1:0] h_use;
    logic [CW-1:0] col_start, col_cur;
    logic [RW-1:0] row_start, row_cur;
    logic [RW:0]   row_inc, row_adv;
    logic [XW-1:0] col_inc;

    // width and height in use
    always_comb
    begin
        w_use = XW'(frame_width);
        if (frame_width == '0)
        begin
            w_use = XW'(1);
        end
        else if (XW'(frame_width) > XW'(MAX_WIDTH))
        begin
            w_use = XW'(MAX_WIDTH);
        end
        h_use = (frame_height == '0) ? RW'(1) : frame_height;
    end

    // position of the incoming word and of the one after it
    always_comb
    begin
        col_start = frame_start ? '0 : col_reg;
        row_start = frame_start ? '0 : row_reg;

        col_cur = col_start;
        row_inc = {1'b0, row_start};
        if (XW'(col_start) >= w_use)
        begin
            col_cur = '0;
            row_inc = {1'b0, row_start} + (RW+1)'(1);
        end
        row_cur = (row_inc >= {1'b0, h_use}) ? '0 : row_inc[RW-1:0];

        col_inc = XW'(col_cur) + XW'(1);
        flags.has_right = (col_inc < w_use);
        flags.cand = (row_cur >= RW'(2)) && (col_cur != '0) &&
                     ((col_inc + XW'(1)) <= w_use);

        row_adv  = {1'b0, row_cur} + (RW+1)'(1);
        col_next = col_inc[CW-1:0];
        row_next = row_cur;
        if (col_inc >= w_use)
        begin
            col_next = '0;
            row_next = (row_adv >= {1'b0, h_use}) ? '0 : row_adv[RW-1:0];
        end
    end

    // counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col       = col_cur;
    assign col_right = col_inc[CW-1:0];
    assign row       = row_cur;

endmodule

`default_nettype wire

/* hdl/pwlm_fifo.sv */
// two-entry result queue that decouples the compare stage from the receiver
`timescale 1ns / 1ps
`default_nettype none

module pwlm_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire pwlm_pkg::peak_t push_data,
    output logic                 full,
    pwlm_peak_if.source          peaks
);

    pwlm_pkg::peak_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg, count_next;
    logic            pop;
    pwlm_pkg::peak_t head;

    assign pop  = peaks.valid && peaks.ready;
    assign full = (count_reg == 2'd2);
    assign head = slot_reg[rd_ptr_reg];

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // output word
    assign peaks.valid      = (count_reg != 2'd0);
    assign peaks.peak_row   = head.row;
    assign peaks.peak_col   = head.col;
    assign peaks.peak_value = head.value;

endmodule

`default_nettype wire

/* hdl/plus_window_local_max_finder_unit.sv */
// top level of the plus-window local maximum finder
//
// Usage: pixels arrive in raster order on the pixel channel, one word per
// handshake; frame_start on a word makes it row 0, column 0. A pixel of an
// interior position is reported on the peak channel with its row, column and
// value when it is strictly larger than its up, down, left and right neighbours.
// The decision is taken with the word directly below it in the compare stage, so
// reports come out in raster order, and no input word yields more than one report.
// Throughput: one pixel per clock unless the stage is stalled; the line stores are read
// on acceptance and written back when the word leaves the compare stage, with a bypass
// for back-to-back accesses to the same column.
// Reports: the deciding word is registered in the compare stage, and its report is then
// pushed into the result queue, whose head is presented on the peak channel.
// Stalls: reports go into a two-entry queue; pixel ready falls only while
// the queue is full and the compare stage holds a word.
// Reset: counters go to row 0, column 0, frame_width and frame_height to
// 1024. The line stores are not cleared; they fill as the first rows pass. The user must
// write configuration through cfg_write/cfg_index/cfg_data only while idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none

module plus_window_local_max_finder_unit #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    pwlm_pixel_if.sink                               pixels,
    pwlm_peak_if.source                              peaks,
    input  wire logic                                cfg_write,
    input  wire logic [pwlm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pwlm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    // configuration registers
    logic [pwlm_pkg::FW_W-1:0] frame_width_reg;
    logic [pwlm_pkg::FH_W-1:0] frame_height_reg;

    // position of the incoming word
    logic                  accept;
    logic [CW-1:0]         pos_col, pos_col_right;
    pwlm_pkg::row_t        pos_row;
    pwlm_pkg::pos_flags_t  pos_flags;

    // compare stage
    logic                  s1_valid_reg;
    pwlm_pkg::sample_t     s1_px_reg;
    pwlm_pkg::row_t        s1_row_reg;
    logic [CW-1:0]         s1_col_reg;
    pwlm_pkg::pos_flags_t  s1_flags_reg;
    logic                  hit_c_reg, hit_r_reg;
    pwlm_pkg::sample_t     fwd_px_reg, fwd_centre_reg;
    pwlm_pkg::sample_t     left_reg;
    logic                  s1_go, s1_write;

    // line store read data
    pwlm_pkg::sample_t     older_rd, recent_rd, right_rd;
    pwlm_pkg::sample_t     up, centre, right;
    logic                  report;
    logic                  queue_full;
    pwlm_pkg::peak_t       peak_word;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= pwlm_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= pwlm_pkg::FRAME_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pwlm_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[pwlm_pkg::FW_W-1:0];
                pwlm_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[pwlm_pkg::FH_W-1:0];
                default: ;
            endcase
        end
    end

    // input handshake
    assign s1_go        = !s1_valid_reg || !queue_full;
    assign s1_write     = s1_valid_reg && s1_go;
    assign pixels.ready = s1_go;
    assign accept       = pixels.valid && s1_go;

    pwlm_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (accept),
        .frame_start  (pixels.frame_start),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .col          (pos_col),
        .col_right    (pos_col_right),
        .row          (pos_row),
        .flags        (pos_flags)
    );

    // line stores: row two above, row above, and a copy of the row above for the right tap
    pwlm_ram #(
        .WIDTH (pwlm_pkg::SAMPLE_W),
        .DEPTH (MAX_WIDTH)
    ) u_older (
        .clk   (clk),
        .we    (s1_write),
        .waddr (s1_col_reg),
        .wdata (centre),
        .re    (accept),
        .raddr (pos_col),
        .rdata (older_rd)
    );

    pwlm_ram #(
        .WIDTH (pwlm_pkg::SAMPLE_W),
        .DEPTH (MAX_WIDTH)
    ) u_recent (
        .clk   (clk),
        .we    (s1_write),
        .waddr (s1_col_reg),
        .wdata (s1_px_reg),
        .re    (accept),
        .raddr (pos_col),
        .rdata (recent_rd)
    );

    pwlm_ram #(
        .WIDTH (pwlm_pkg::SAMPLE_W),
        .DEPTH (MAX_WIDTH)
    ) u_recent_right (
        .clk   (clk),
        .we    (s1_write),
        .waddr (s1_col_reg),
        .wdata (s1_px_reg),
        .re    (accept),
        .raddr (pos_col_right),
        .rdata (right_rd)
    );

    // compare stage registers, with bypass of the write made at the accept edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            left_reg     <= '0;
        end
        else
        begin
            if (s1_go)
            begin
                s1_valid_reg <= pixels.valid;
            end
            if (s1_write)
            begin
                left_reg <= centre;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg      <= pixels.pixel_value;
            s1_row_reg     <= pos_row;
            s1_col_reg     <= pos_col;
            s1_flags_reg   <= pos_flags;
            hit_c_reg      <= s1_valid_reg && (s1_col_reg == pos_col);
            hit_r_reg      <= s1_valid_reg && (s1_col_reg == pos_col_right);
            fwd_px_reg     <= s1_px_reg;
            fwd_centre_reg <= centre;
        end
    end

    // plus-window compare
    always_comb
    begin
        up     = hit_c_reg ? fwd_centre_reg : older_rd;
        centre = hit_c_reg ? fwd_px_reg : recent_rd;
        right  = '0;
        if (s1_flags_reg.has_right)
        begin
            right = hit_r_reg ? fwd_px_reg : right_rd;
        end
        report = s1_valid_reg && s1_flags_reg.cand &&
                 (centre > up) && (centre > s1_px_reg) &&
                 (centre > left_reg) && (centre > right);
    end

    // report word
    assign peak_word.row   = s1_row_reg - pwlm_pkg::row_t'(1);
    assign peak_word.col   = pwlm_pkg::peak_col_t'(32'(s1_col_reg));
    assign peak_word.value = centre;

    pwlm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (report && s1_go),
        .push_data (peak_word),
        .full      (queue_full),
        .peaks     (peaks)
    );

endmodule

`default_nettype wire
